FILE: hw/rtl/command_line_tokenizer_macros.svh
// Assertion macros shared by the tokenizer checker.
// Needs nothing else; included by name where assertions are written.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

FILE: hw/rtl/clt_pkg.sv
// Package for the command-line tokenizer: character codes and result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clt_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NONE   = 8'h00;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_char;
    logic [7:0] repeat_count;
    logic       arg_end;
    logic       last_of_run;
  } clt_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/command_line_tokenizer.sv
// Command-line tokenizer top level: input register, tokenizer state, result queue.
// Depends on clt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Beat
// in        sink       in_valid_i / in_stall_o char_code_i, is_end_i
// out       source     out_valid_o/out_stall_i out_char_o, repeat_count_o,
//                                              arg_end_o, last_of_run_o
//
// A beat lands in the input register, then is decoded combinationally into zero,
// one or two result beats that enter a two-entry result queue.
// One input beat per cycle is taken while beats yield at most one result and the
// output is not stalled; a beat yielding two results waits for queue room for both.
// Reset clears the tokenizer state, the input register's valid bit and the queue count.
// A stalled output backs up into the input register, which then stalls the input.

module command_line_tokenizer
  import clt_pkg::*;
#(
  parameter int MAX_BACKSLASH_RUN = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       is_end_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [7:0] out_char_o,
  output      logic [7:0] repeat_count_o,
  output      logic       arg_end_o,
  output      logic       last_of_run_o
);

  // Held backslash count saturates at the parameter, but never past 8 bits.
  localparam int          RunBoundInt = (MAX_BACKSLASH_RUN > 255) ? 255 : MAX_BACKSLASH_RUN;
  localparam logic [7:0]  RunBound    = RunBoundInt[7:0];

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_end_q;

  // Tokenizer state.
  logic [7:0] run_q, run_d;
  logic       inq_q, inq_d;
  logic       tok_q, tok_d;

  // Result queue; entry 0 is on the output port.
  clt_result_t ent_q [2];
  clt_result_t ent_d [2];
  logic [1:0]  cnt_q, cnt_d;

  // Decoded results of the held beat.
  clt_result_t res [2];
  logic [1:0]  n_res;

  logic       pop;
  logic [1:0] free_after;
  logic       advance;
  logic       take_in;

  // Decode: one beat against the current state.
  always_comb begin
    clt_result_t r0;
    clt_result_t r1;
    r0    = '{out_char: CH_NONE, repeat_count: 8'd0, arg_end: 1'b0, last_of_run: 1'b0};
    r1    = r0;
    n_res = 2'd0;
    run_d = run_q;
    inq_d = inq_q;
    tok_d = tok_q;

    if (in_end_q) begin
      // Flush the run, close an open argument, then back to reset state.
      if (run_q != 8'd0) begin
        r0    = '{out_char: CH_BSLASH, repeat_count: run_q, arg_end: 1'b1, last_of_run: 1'b1};
        n_res = 2'd1;
      end else if (tok_q) begin
        r0    = '{out_char: CH_NONE, repeat_count: 8'd0, arg_end: 1'b1, last_of_run: 1'b1};
        n_res = 2'd1;
      end
      run_d = 8'd0;
      inq_d = 1'b0;
      tok_d = 1'b0;
    end else if (in_char_q == CH_BSLASH) begin
      if (run_q < RunBound) begin
        run_d = run_q + 8'd1;
      end
      tok_d = 1'b1;
    end else if (in_char_q == CH_QUOTE) begin
      // Half the run goes out; odd run adds a literal quote, even toggles quoting.
      if ((run_q >> 1) != 8'd0) begin
        r0    = '{out_char: CH_BSLASH, repeat_count: run_q >> 1, arg_end: 1'b0,
                  last_of_run: ~run_q[0]};
        n_res = 2'd1;
        if (run_q[0]) begin
          r1    = '{out_char: CH_QUOTE, repeat_count: 8'd1, arg_end: 1'b0, last_of_run: 1'b1};
          n_res = 2'd2;
        end
      end else if (run_q[0]) begin
        r0    = '{out_char: CH_QUOTE, repeat_count: 8'd1, arg_end: 1'b0, last_of_run: 1'b1};
        n_res = 2'd1;
      end
      if (!run_q[0]) begin
        inq_d = ~inq_q;
      end
      run_d = 8'd0;
      tok_d = 1'b1;
    end else if (!inq_q && (in_char_q == CH_SPACE || in_char_q == CH_TAB)) begin
      // Unquoted separator closes the argument.
      if (run_q != 8'd0) begin
        r0    = '{out_char: CH_BSLASH, repeat_count: run_q, arg_end: 1'b1, last_of_run: 1'b1};
        n_res = 2'd1;
      end else if (tok_q) begin
        r0    = '{out_char: CH_NONE, repeat_count: 8'd0, arg_end: 1'b1, last_of_run: 1'b1};
        n_res = 2'd1;
      end
      run_d = 8'd0;
      tok_d = 1'b0;
    end else begin
      // Ordinary character, preceded by any held run.
      if (run_q != 8'd0) begin
        r0    = '{out_char: CH_BSLASH, repeat_count: run_q, arg_end: 1'b0, last_of_run: 1'b0};
        r1    = '{out_char: in_char_q, repeat_count: 8'd1, arg_end: 1'b0, last_of_run: 1'b1};
        n_res = 2'd2;
      end else begin
        r0    = '{out_char: in_char_q, repeat_count: 8'd1, arg_end: 1'b0, last_of_run: 1'b1};
        n_res = 2'd1;
      end
      run_d = 8'd0;
      tok_d = 1'b1;
    end
    res[0] = r0;
    res[1] = r1;
  end

  // Flow control: the held beat moves on once the queue has room for all its results.
  assign pop        = (cnt_q != 2'd0) && !out_stall_i;
  assign free_after = 2'd2 - cnt_q + {1'b0, pop};
  assign advance    = in_valid_q && (n_res <= free_after);
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  // Queue update: pop from the head, then append the new results.
  always_comb begin
    logic [1:0] cnt_pop;
    cnt_pop  = cnt_q - {1'b0, pop};
    ent_d[0] = pop ? ent_q[1] : ent_q[0];
    ent_d[1] = ent_q[1];
    cnt_d    = cnt_pop;
    if (advance) begin
      if (n_res == 2'd2) begin
        ent_d[0] = res[0];
        ent_d[1] = res[1];
      end else if (n_res == 2'd1) begin
        ent_d[cnt_pop[0]] = res[0];
      end
      cnt_d = cnt_pop + n_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      run_q      <= 8'd0;
      inq_q      <= 1'b0;
      tok_q      <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        run_q <= run_d;
        inq_q <= inq_d;
        tok_q <= tok_d;
      end
      cnt_q <= cnt_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_char_q <= char_code_i;
      in_end_q  <= is_end_i;
    end
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign out_char_o     = ent_q[0].out_char;
  assign repeat_count_o = ent_q[0].repeat_count;
  assign arg_end_o      = ent_q[0].arg_end;
  assign last_of_run_o  = ent_q[0].last_of_run;

endmodule

`default_nettype wire

FILE: hw/rtl/clt_checker.sv
// Port-level checker for the command-line tokenizer, bound to the top level.
// Depends on clt_pkg and command_line_tokenizer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "command_line_tokenizer_macros.svh"

module clt_checker
  import clt_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_char_o,
  input wire logic [7:0] repeat_count_o,
  input wire logic       arg_end_o,
  input wire logic       last_of_run_o
);

  // A stalled result beat stays and holds its payload.
  `CLT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_char_o) && $stable(repeat_count_o) && $stable(arg_end_o) && $stable(last_of_run_o))

  // Only a pure argument end carries nothing to append.
  `CLT_ASSERT_NOW(a_empty_is_end, clk_i, rst_ni, out_valid_o && (repeat_count_o == 8'd0), arg_end_o && (out_char_o == CH_NONE))

  // An argument end is always the final beat of its input.
  `CLT_ASSERT_NOW(a_end_is_last, clk_i, rst_ni, out_valid_o && arg_end_o, last_of_run_o)

  // A quote is only ever emitted singly, inside an argument.
  `CLT_ASSERT_NOW(a_quote_single, clk_i, rst_ni, out_valid_o && (out_char_o == CH_QUOTE), (repeat_count_o == 8'd1) && !arg_end_o)

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_char_o     (out_char_o),
  .repeat_count_o (repeat_count_o),
  .arg_end_o      (arg_end_o),
  .last_of_run_o  (last_of_run_o)
);

`default_nettype wire

FILE: tb/tb_command_line_tokenizer.sv
// Self-checking testbench for command_line_tokenizer: character beats in, append beats out.
// Keeps its own tokenizer state to predict every result beat; needs clt_pkg and the block.
`timescale 1ns / 1ps

module tb_command_line_tokenizer;
  import clt_pkg::*;

  // Block build and the tokenizer's effective cap on a held backslash run.
  localparam int MAX_RUN = 255;
  localparam int RUN_CAP = (MAX_RUN > 255) ? 255 : MAX_RUN;

  localparam int IDLE_TOP     = 17;    // longest gap or stall drawn per beat
  localparam int ITEM_GOAL    = 1800;  // stimulus stops once this many beats went in
  localparam int REPORT_LIMIT = 10;    // mismatches printed in full

  // Ordinary characters used by the directed cases.
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_ALL_SET = 8'hFF;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [7:0] char_code_i    = '0;
  logic       is_end_i       = 1'b0;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_char_o;
  logic [7:0] repeat_count_o;
  logic       arg_end_o;
  logic       last_of_run_o;

  // Shadow of the tokenizer state, in its reset values.
  logic [7:0] bs_run   = '0;    // length of the held backslash run
  logic       quoted   = 1'b0;  // inside a quoted section
  logic       arg_open = 1'b0;  // an argument has been started

  // Append beats still owed by the block, oldest first.
  clt_result_t expected_appends[$];

  int errors     = 0;
  int items_sent = 0;

  // Per-phase idling bounds; zero gives stretches with no idling at all.
  int send_idle_max = IDLE_TOP;
  int recv_idle_max = IDLE_TOP;

  command_line_tokenizer #(
    .MAX_BACKSLASH_RUN(MAX_RUN)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .is_end_i      (is_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .repeat_count_o(repeat_count_o),
    .arg_end_o     (arg_end_o),
    .last_of_run_o (last_of_run_o)
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic clt_result_t append_beat(input logic [7:0] ch, input logic [7:0] cnt,
                                              input logic done);
    clt_result_t b;
    b.out_char     = ch;
    b.repeat_count = cnt;
    b.arg_end      = done;
    b.last_of_run  = 1'b0;
    return b;
  endfunction

  // Add one beat at the tail of the owed list.
  function automatic void owe_beat(input clt_result_t b);
    expected_appends.insert(expected_appends.size(), b);
  endfunction

  // Advance the shadow tokenizer by one character (or end marker) and queue
  // the append beats it owes, in order, the last one flagged.
  function automatic void tokenize_step(input logic [7:0] c, input logic fin);
    int          base;
    logic [7:0]  run;
    base = expected_appends.size();
    run  = bs_run;
    if (fin) begin
      // flush the run, or close an open argument, then start over
      if (run != 0) owe_beat(append_beat(CH_BSLASH, run, 1'b1));
      else if (arg_open) owe_beat(append_beat(CH_NONE, 8'd0, 1'b1));
      bs_run   = '0;
      quoted   = 1'b0;
      arg_open = 1'b0;
    end else if (c == CH_BSLASH) begin
      // held, not appended; saturates at the cap
      if (run < RUN_CAP) bs_run = run + 8'd1;
      arg_open = 1'b1;
    end else if (c == CH_QUOTE) begin
      // half the run goes out; odd run escapes the quote, even run toggles quoting
      if ((run >> 1) != 0) owe_beat(append_beat(CH_BSLASH, run >> 1, 1'b0));
      if (run[0]) owe_beat(append_beat(CH_QUOTE, 8'd1, 1'b0));
      else quoted = !quoted;
      bs_run   = '0;
      arg_open = 1'b1;
    end else if (!quoted && (c == CH_SPACE || c == CH_TAB)) begin
      // blank outside quotes: the run and the argument end share one beat
      if (run != 0) owe_beat(append_beat(CH_BSLASH, run, 1'b1));
      else if (arg_open) owe_beat(append_beat(CH_NONE, 8'd0, 1'b1));
      bs_run   = '0;
      arg_open = 1'b0;
    end else begin
      // any other character, NUL included: whole run, then the character
      if (run != 0) owe_beat(append_beat(CH_BSLASH, run, 1'b0));
      owe_beat(append_beat(c, 8'd1, 1'b0));
      bs_run   = '0;
      arg_open = 1'b1;
    end
    if (expected_appends.size() > base)
      expected_appends[expected_appends.size() - 1].last_of_run = 1'b1;
  endfunction

  // Offer one character beat after a random gap and hold it until taken.
  // Called on a rising edge; valid is only lowered when a gap follows, so a
  // back-to-back beat never sees valid dropped and raised in one step.
  task automatic send_item(input logic [7:0] c, input logic fin);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    is_end_i    <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tokenize_step(c, fin);
    items_sent++;
  endtask

  // Weighted toward the characters that steer the tokenizer.
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return CH_LOWER_A + 8'($urandom_range(0, 25));
    if (roll < 40) return CH_SPACE;
    if (roll < 45) return CH_TAB;
    if (roll < 60) return CH_QUOTE;
    if (roll < 80) return CH_BSLASH;
    return 8'($urandom_range(0, 255));
  endfunction

  // Short hand-picked lines: field extremes and each quoting rule.
  task automatic test_directed_cases();
    send_item(CH_LOWER_X, 1'b1);   // end marker with nothing open: no beat
    send_item(CH_NONE, 1'b0);      // NUL is appended like any character
    send_item(CH_ALL_SET, 1'b0);
    send_item(CH_SPACE, 1'b0);     // blank closes the argument
    repeat (2) send_item(CH_BSLASH, 1'b0);
    send_item(CH_SPACE, 1'b0);     // run of two and arg end in one beat
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_QUOTE, 1'b0);     // lone backslash escapes quote: quote beat only
    repeat (2) send_item(CH_BSLASH, 1'b0);
    send_item(CH_QUOTE, 1'b0);     // even run: one backslash, quoting turns on
    send_item(CH_TAB, 1'b0);       // quoted blanks are plain characters
    send_item(CH_SPACE, 1'b0);
    send_item(CH_QUOTE, 1'b0);     // quoting off
    repeat (3) send_item(CH_BSLASH, 1'b0);
    send_item(CH_QUOTE, 1'b0);     // odd run of three: one backslash plus a quote
    send_item(CH_TAB, 1'b0);
    repeat (2) send_item(CH_QUOTE, 1'b0);
    send_item(CH_SPACE, 1'b0);     // pair of quotes alone gives an empty argument
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_NONE, 1'b1);      // end flushes the held run
    send_item(CH_LOWER_A, 1'b0);
    send_item(CH_ALL_SET, 1'b1);   // end closes the open argument
  endtask

  // Runs at and past the cap; extra backslashes beyond it are dropped.
  task automatic test_backslash_saturation();
    send_idle_max = 0;
    recv_idle_max = IDLE_TOP;
    repeat (RUN_CAP) send_item(CH_BSLASH, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    repeat ($urandom_range(RUN_CAP + 1, RUN_CAP + 25)) send_item(CH_BSLASH, 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_idle_max = IDLE_TOP;
  endtask

  // Mostly framed command lines with random content; some left unterminated
  // so state carries over, some pure noise with stray end markers.
  task automatic test_random_cmdlines();
    int len;
    int roll;
    while (items_sent < ITEM_GOAL) begin
      roll          = $urandom_range(0, 9);
      len           = $urandom_range(1, 40);
      send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_TOP;
      recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_TOP;
      if (roll == 0) begin
        repeat (len) send_item(8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        repeat (len) send_item(pick_char(), 1'b0);
        if (roll != 1) send_item(8'($urandom), 1'b1);
      end
    end
  endtask

  // Output side backpressure: after each taken beat, stall for a random count.
  initial begin : recv_stall
    int hold;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        hold = $urandom_range(0, recv_idle_max);
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Compare every taken result beat with the oldest owed append.
  always @(posedge clk_i) begin
    clt_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_appends.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected beat: char %h count %0d end %b last %b",
                   out_char_o, repeat_count_o, arg_end_o, last_of_run_o);
      end else begin
        want = expected_appends.pop_front();
        if (out_char_o !== want.out_char || repeat_count_o !== want.repeat_count ||
            arg_end_o !== want.arg_end || last_of_run_o !== want.last_of_run) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("mismatch: want char %h count %0d end %b last %b, got %h %0d %b %b",
                     want.out_char, want.repeat_count, want.arg_end, want.last_of_run,
                     out_char_o, repeat_count_o, arg_end_o, last_of_run_o);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_backslash_saturation();
    test_random_cmdlines();
    in_valid_i <= 1'b0;
    // drain, then wait for any stray beat to show
    while (expected_appends.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_appends.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
